// ===== rtl/core/window_color_average_defines.svh =====
// ----------------------------------------------------------------------------
// Window colour average: assertion macros
// Shared concurrent assertion forms, clocked on clk and quiet during reset.
// ----------------------------------------------------------------------------
`ifndef WINDOW_COLOR_AVERAGE_DEFINES_SVH
`define WINDOW_COLOR_AVERAGE_DEFINES_SVH

// Property checked on every clock edge outside reset.
`define WCA_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define WCA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/wca_pkg.sv =====
// ----------------------------------------------------------------------------
// Window colour average: package
// Field widths, register indexes, reset values and shared structs.
// ----------------------------------------------------------------------------
package wca_pkg;

    localparam int MAX_DIM_DEF   = 4096;
    localparam int RED_POS_DEF   = 16;
    localparam int GREEN_POS_DEF = 8;
    localparam int BLUE_POS_DEF  = 0;

    localparam int LEFT_W     = 13;
    localparam int COLS_W     = 14;
    localparam int FRAME_W    = 13;
    localparam int CFG_DATA_W = 14;
    localparam int CFG_IDX_W  = 3;
    localparam int PIXEL_W    = 32;
    localparam int CHAN_W     = 8;
    localparam int CHAN_N     = 3;
    localparam int SUM_W      = 40;
    localparam int STEP_W     = $clog2(CHAN_W);

    localparam logic [CHAN_W-1:0] CHAN_MAX = 8'hff;

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEFT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_TOP  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_COLS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_ROWS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_COLS  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_ROWS  = 3'd5;

    localparam logic [LEFT_W-1:0]  WINDOW_LEFT_RST = 13'd0;
    localparam logic [LEFT_W-1:0]  WINDOW_TOP_RST  = 13'd0;
    localparam logic [COLS_W-1:0]  WINDOW_COLS_RST = 14'd1;
    localparam logic [COLS_W-1:0]  WINDOW_ROWS_RST = 14'd1;
    localparam logic [FRAME_W-1:0] FRAME_COLS_RST  = 13'd640;
    localparam logic [FRAME_W-1:0] FRAME_ROWS_RST  = 13'd480;

    typedef struct packed {
        logic signed [LEFT_W-1:0] window_left;
        logic signed [LEFT_W-1:0] window_top;
        logic signed [COLS_W-1:0] window_cols;
        logic signed [COLS_W-1:0] window_rows;
        logic [FRAME_W-1:0]       frame_cols;
        logic [FRAME_W-1:0]       frame_rows;
    } cfg_t;

    typedef struct packed {
        logic pix_accept;
        logic frame_close;
        logic area_load;
        logic div_check;
        logic div_step;
        logic out_load;
    } dp_cmd_t;

endpackage

// ===== rtl/core/window_color_average.sv =====
// ----------------------------------------------------------------------------
// Window colour average: top level
// Mean red, green and blue over a clipped rectangle of a raster-order frame.
// ----------------------------------------------------------------------------
// Pixels are taken one per clock while a frame streams. The pixel marked
// frame_last closes the frame: input is then held off through the window
// area multiply, the range check, eight restoring division steps giving one
// quotient bit per channel each, and the load of the output register, and
// longer if the previous result has not yet been taken. A result waiting at
// the output does not stop the next frame's pixels. Window registers take
// effect on the next pixel.
module window_color_average import wca_pkg::*; #(
    parameter int MAX_DIM   = MAX_DIM_DEF,
    parameter int RED_POS   = RED_POS_DEF,
    parameter int GREEN_POS = GREEN_POS_DEF,
    parameter int BLUE_POS  = BLUE_POS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [PIXEL_W-1:0]    pixel,
    input  logic                  frame_last,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [PIXEL_W-1:0]    mean_pixel,
    output logic                  window_empty,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t    cfg;
    dp_cmd_t cmd;

    wca_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    wca_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .frame_last (frame_last),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .cmd        (cmd)
    );

    wca_datapath #(
        .MAX_DIM   (MAX_DIM),
        .RED_POS   (RED_POS),
        .GREEN_POS (GREEN_POS),
        .BLUE_POS  (BLUE_POS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .cfg          (cfg),
        .pixel        (pixel),
        .mean_pixel   (mean_pixel),
        .window_empty (window_empty)
    );

endmodule

// ===== rtl/core/wca_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// Window colour average: configuration registers
// Six window and frame registers, written one request at a time.
// ----------------------------------------------------------------------------
module wca_cfg_regs import wca_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_WINDOW_LEFT: cfg_next.window_left = cfg_data[LEFT_W-1:0];
                REG_WINDOW_TOP:  cfg_next.window_top  = cfg_data[LEFT_W-1:0];
                REG_WINDOW_COLS: cfg_next.window_cols = cfg_data[COLS_W-1:0];
                REG_WINDOW_ROWS: cfg_next.window_rows = cfg_data[COLS_W-1:0];
                REG_FRAME_COLS:  cfg_next.frame_cols  = cfg_data[FRAME_W-1:0];
                REG_FRAME_ROWS:  cfg_next.frame_rows  = cfg_data[FRAME_W-1:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.window_left <= WINDOW_LEFT_RST;
            cfg_reg.window_top  <= WINDOW_TOP_RST;
            cfg_reg.window_cols <= WINDOW_COLS_RST;
            cfg_reg.window_rows <= WINDOW_ROWS_RST;
            cfg_reg.frame_cols  <= FRAME_COLS_RST;
            cfg_reg.frame_rows  <= FRAME_ROWS_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== rtl/core/wca_ctrl.sv =====
// ----------------------------------------------------------------------------
// Window colour average: controller
// Sequences pixel intake, the frame-end area multiply and the mean division,
// and owns the result handshake.
// ----------------------------------------------------------------------------
`include "window_color_average_defines.svh"

module wca_ctrl import wca_pkg::*; (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  logic    frame_last,
    output logic    out_valid,
    input  logic    out_ready,
    output dp_cmd_t cmd
);

    localparam logic [2:0] S_RUN   = 3'd0;
    localparam logic [2:0] S_AREA  = 3'd1;
    localparam logic [2:0] S_CHECK = 3'd2;
    localparam logic [2:0] S_DIV   = 3'd3;
    localparam logic [2:0] S_OUT   = 3'd4;

    logic [2:0]        state_reg;
    logic [2:0]        state_next;
    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    logic              out_valid_reg;
    logic              out_valid_next;

    assign in_ready  = (state_reg == S_RUN);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_RUN:
            begin
                if (in_valid)
                begin
                    cmd.pix_accept = 1'b1;
                    if (frame_last)
                    begin
                        cmd.frame_close = 1'b1;
                        state_next      = S_AREA;
                    end
                end
            end
            S_AREA:
            begin
                cmd.area_load = 1'b1;
                state_next    = S_CHECK;
            end
            S_CHECK:
            begin
                cmd.div_check = 1'b1;
                step_next     = STEP_W'(CHAN_W - 1);
                state_next    = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (step_reg == '0)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    step_next = step_reg - STEP_W'(1);
                end
            end
            S_OUT:
            begin
                // output slot free, or being emptied this cycle
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_RUN;
                end
            end
            default:
            begin
                state_next = S_RUN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_RUN;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `WCA_ASSERT_NEXT(a_close_holds_input, in_valid && in_ready && frame_last, !in_ready, "pixel taken during frame-end division")
    `WCA_ASSERT(a_load_free_slot, cmd.out_load |-> (!out_valid_reg || out_ready), "result overwritten before taken")
    `WCA_ASSERT_NEXT(a_load_shows_valid, cmd.out_load, out_valid_reg, "loaded result not presented")
    `WCA_ASSERT(a_div_length, (state_reg == S_CHECK) |=> ##8 (state_reg == S_OUT), "division step count wrong")

endmodule

// ===== rtl/core/wca_datapath.sv =====
// ----------------------------------------------------------------------------
// Window colour average: datapath
// Raster position, window clip, channel accumulators, area multiply and a
// restoring divider that yields one quotient bit per channel per step.
// ----------------------------------------------------------------------------
module wca_datapath import wca_pkg::*; #(
    parameter int MAX_DIM   = MAX_DIM_DEF,
    parameter int RED_POS   = RED_POS_DEF,
    parameter int GREEN_POS = GREEN_POS_DEF,
    parameter int BLUE_POS  = BLUE_POS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  dp_cmd_t            cmd,
    input  cfg_t               cfg,
    input  logic [PIXEL_W-1:0] pixel,
    output logic [PIXEL_W-1:0] mean_pixel,
    output logic               window_empty
);

    localparam int IDX_W  = $clog2(MAX_DIM);
    localparam int DIM_W  = $clog2(MAX_DIM + 1);
    localparam int CLIP_W = ((DIM_W > COLS_W) ? DIM_W : COLS_W) + 1;
    localparam int AREA_W = 2 * DIM_W;
    localparam int CMP_W  = (AREA_W + CHAN_W > SUM_W) ? AREA_W + CHAN_W : SUM_W;
    localparam int CHAN_POS [CHAN_N] = '{RED_POS, GREEN_POS, BLUE_POS};

    localparam logic signed [CLIP_W-1:0] DIM_MAX = CLIP_W'(MAX_DIM);
    localparam logic signed [CLIP_W-1:0] ONE_S   = CLIP_W'(1);
    localparam logic signed [CLIP_W-1:0] ZERO_S  = CLIP_W'(0);

    // frame size saturated to 1..MAX_DIM
    function automatic logic signed [CLIP_W-1:0] sat_dim(input logic [FRAME_W-1:0] v);
        logic signed [CLIP_W-1:0] w;
        w = $signed({{(CLIP_W-FRAME_W){1'b0}}, v});
        if (v == '0)
            sat_dim = ONE_S;
        else if (w > DIM_MAX)
            sat_dim = DIM_MAX;
        else
            sat_dim = w;
    endfunction

    logic [IDX_W-1:0]         col_reg;
    logic [IDX_W-1:0]         row_reg;
    logic [IDX_W-1:0]         col_next;
    logic [IDX_W-1:0]         row_next;

    logic signed [CLIP_W-1:0] left_s;
    logic signed [CLIP_W-1:0] top_s;
    logic signed [CLIP_W-1:0] cols_s;
    logic signed [CLIP_W-1:0] rows_s;
    logic signed [CLIP_W-1:0] fc;
    logic signed [CLIP_W-1:0] fr;
    logic signed [CLIP_W-1:0] x_end;
    logic signed [CLIP_W-1:0] y_end;
    logic signed [CLIP_W-1:0] x0;
    logic signed [CLIP_W-1:0] x1;
    logic signed [CLIP_W-1:0] y0;
    logic signed [CLIP_W-1:0] y1;
    logic signed [CLIP_W-1:0] col_s;
    logic signed [CLIP_W-1:0] row_s;
    logic                     nonempty;
    logic                     in_win;
    logic                     col_wrap;
    logic                     row_wrap;
    logic [DIM_W-1:0]         x_span;
    logic [DIM_W-1:0]         y_span;

    logic [DIM_W-1:0]         x_span_reg;
    logic [DIM_W-1:0]         y_span_reg;
    logic                     empty_reg;
    logic [AREA_W-1:0]        area_reg;
    logic [CMP_W-1:0]         div_reg;
    logic [CMP_W-1:0]         lim;

    logic [SUM_W-1:0]         sum_reg  [CHAN_N];
    logic [SUM_W-1:0]         sum_next [CHAN_N];
    logic [CMP_W-1:0]         rem_reg  [CHAN_N];
    logic [CHAN_W-1:0]        q_reg    [CHAN_N];
    logic                     sat_reg  [CHAN_N];
    logic [PIXEL_W-1:0]       placed   [CHAN_N];

    logic [PIXEL_W-1:0]       mean_pixel_reg;
    logic                     window_empty_reg;

    // window clip against the frame edges
    assign left_s = $signed({{(CLIP_W-LEFT_W){cfg.window_left[LEFT_W-1]}}, cfg.window_left});
    assign top_s  = $signed({{(CLIP_W-LEFT_W){cfg.window_top[LEFT_W-1]}}, cfg.window_top});
    assign cols_s = $signed({{(CLIP_W-COLS_W){cfg.window_cols[COLS_W-1]}}, cfg.window_cols});
    assign rows_s = $signed({{(CLIP_W-COLS_W){cfg.window_rows[COLS_W-1]}}, cfg.window_rows});
    assign fc     = sat_dim(cfg.frame_cols);
    assign fr     = sat_dim(cfg.frame_rows);

    assign x_end  = left_s + cols_s;
    assign y_end  = top_s + rows_s;
    assign x0     = (left_s < ZERO_S) ? ZERO_S : left_s;
    assign y0     = (top_s < ZERO_S) ? ZERO_S : top_s;
    assign x1     = (x_end > fc) ? fc : x_end;
    assign y1     = (y_end > fr) ? fr : y_end;

    assign nonempty = (x1 > x0) && (y1 > y0);
    assign x_span   = nonempty ? DIM_W'(x1 - x0) : '0;
    assign y_span   = nonempty ? DIM_W'(y1 - y0) : '0;

    assign col_s  = $signed({{(CLIP_W-IDX_W){1'b0}}, col_reg});
    assign row_s  = $signed({{(CLIP_W-IDX_W){1'b0}}, row_reg});
    assign in_win = nonempty && (col_s >= x0) && (col_s < x1)
                    && (row_s >= y0) && (row_s < y1);

    // raster position of the next pixel
    assign col_wrap = (col_s + ONE_S) >= fc;
    assign row_wrap = (row_s + ONE_S) >= fr;

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (cmd.frame_close)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (cmd.pix_accept)
        begin
            if (col_wrap)
            begin
                col_next = '0;
                row_next = row_wrap ? '0 : row_reg + IDX_W'(1);
            end
            else
            begin
                col_next = col_reg + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // area and divisor
    assign lim = CMP_W'(area_reg) << CHAN_W;

    always_ff @(posedge clk)
    begin
        if (cmd.frame_close)
        begin
            x_span_reg <= x_span;
            y_span_reg <= y_span;
            empty_reg  <= !nonempty;
        end
        if (cmd.area_load)
        begin
            area_reg <= AREA_W'(x_span_reg) * AREA_W'(y_span_reg);
        end
        if (cmd.div_check)
        begin
            div_reg <= CMP_W'(area_reg) << (CHAN_W - 1);
        end
        else if (cmd.div_step)
        begin
            div_reg <= div_reg >> 1;
        end
    end

    for (genvar i = 0; i < CHAN_N; i++)
    begin : g_chan
        logic [CHAN_W-1:0] chan_byte;
        logic              ge;
        logic [CHAN_W-1:0] mean_byte;

        assign chan_byte = pixel[CHAN_POS[i] +: CHAN_W];
        assign sum_next[i] = sum_reg[i] + (in_win ? SUM_W'(chan_byte) : '0);
        assign ge = rem_reg[i] >= div_reg;
        assign mean_byte = sat_reg[i] ? CHAN_MAX : q_reg[i];
        assign placed[i] = PIXEL_W'(mean_byte) << CHAN_POS[i];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sum_reg[i] <= '0;
            end
            else if (cmd.frame_close)
            begin
                sum_reg[i] <= '0;
            end
            else if (cmd.pix_accept)
            begin
                sum_reg[i] <= sum_next[i];
            end
        end

        always_ff @(posedge clk)
        begin
            if (cmd.frame_close)
            begin
                rem_reg[i] <= CMP_W'(sum_next[i]);
            end
            else if (cmd.div_step && ge)
            begin
                rem_reg[i] <= rem_reg[i] - div_reg;
            end

            if (cmd.div_check)
            begin
                // quotient of 256 or more clamps to a full byte
                sat_reg[i] <= rem_reg[i] >= lim;
                q_reg[i]   <= '0;
            end
            else if (cmd.div_step)
            begin
                q_reg[i] <= {q_reg[i][CHAN_W-2:0], ge};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            mean_pixel_reg   <= empty_reg ? '0 : (placed[0] | placed[1] | placed[2]);
            window_empty_reg <= empty_reg;
        end
    end

    assign mean_pixel   = mean_pixel_reg;
    assign window_empty = window_empty_reg;

endmodule

// ===== verif/tb_top.sv =====
// ----------------------------------------------------------------------------
// Window colour average: testbench
// Streams frames of pixels through the block under changing window and frame
// settings, predicts each frame's channel means and checks every result.
// ----------------------------------------------------------------------------
module tb_top;
    import wca_pkg::*;

    localparam int ITEM_TARGET    = 1850;
    localparam int SETTLE_CYCLES  = 16;
    localparam int HOLD_CYCLES    = 240;
    localparam int QUIET_LIMIT    = 2000;
    localparam int IDLE_PCT       = 25;
    localparam int PRESSURE_PHASE = 10;

    // indexes past the last register; writes there must change nothing
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = REG_FRAME_ROWS + 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = REG_FRAME_ROWS + 3'd2;

    typedef struct packed {
        logic [PIXEL_W-1:0] pixel;
        logic               frame_last;
    } pending_pixel_t;

    typedef struct packed {
        logic [PIXEL_W-1:0] mean_pixel;
        logic               window_empty;
    } mean_result_t;

    logic                  clk          = 1'b0;
    logic                  rst_n        = 1'b0;
    logic                  in_valid     = 1'b0;
    logic                  in_ready;
    logic [PIXEL_W-1:0]    pixel        = '0;
    logic                  frame_last   = 1'b0;
    logic                  out_valid;
    logic                  out_ready    = 1'b0;
    logic [PIXEL_W-1:0]    mean_pixel;
    logic                  window_empty;
    logic                  cfg_valid    = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index    = '0;
    logic [CFG_DATA_W-1:0] cfg_data     = '0;

    // shadow of the block's registers and state
    logic signed [LEFT_W-1:0] win_left  = WINDOW_LEFT_RST;
    logic signed [LEFT_W-1:0] win_top   = WINDOW_TOP_RST;
    logic signed [COLS_W-1:0] win_cols  = WINDOW_COLS_RST;
    logic signed [COLS_W-1:0] win_rows  = WINDOW_ROWS_RST;
    logic [FRAME_W-1:0]       frm_cols  = FRAME_COLS_RST;
    logic [FRAME_W-1:0]       frm_rows  = FRAME_ROWS_RST;
    int                       col_pos   = 0;
    int                       row_pos   = 0;
    logic [SUM_W-1:0]         red_acc   = '0;
    logic [SUM_W-1:0]         green_acc = '0;
    logic [SUM_W-1:0]         blue_acc  = '0;

    pending_pixel_t pixel_pending[$];
    mean_result_t   mean_expect[$];

    int errors        = 0;
    int items_queued  = 0;
    int items_taken   = 0;
    int results_seen  = 0;
    int empty_windows = 0;
    int settings_used = 0;
    int tx_burst      = 0;
    int rx_burst      = 0;
    int rx_hold       = 0;
    int quiet_cycles  = 0;
    bit tx_idle_on    = 1'b1;
    bit rx_idle_on    = 1'b1;
    bit hold_armed    = 1'b0;
    bit hold_done     = 1'b0;

    window_color_average u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .pixel        (pixel),
        .frame_last   (frame_last),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .mean_pixel   (mean_pixel),
        .window_empty (window_empty),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int frame_dim(input logic [FRAME_W-1:0] v);
        if (v == '0)
            return 1;
        if (v > MAX_DIM_DEF)
            return MAX_DIM_DEF;
        return int'(v);
    endfunction

    // half-open span [lo, hi) of one axis after clipping to the frame
    function automatic bit clip_axis(input int start, input int len, input int dim,
                                     output int lo, output int hi);
        lo = (start < 0) ? 0 : start;
        hi = start + len;
        if (hi > dim)
            hi = dim;
        return hi > lo;
    endfunction

    function automatic logic [CHAN_W-1:0] mean_chan(input logic [SUM_W-1:0] sum,
                                                   input longint unsigned area);
        longint unsigned q;
        q = sum / area;
        if (q > CHAN_MAX)
            return CHAN_MAX;
        return q[CHAN_W-1:0];
    endfunction

    function automatic void set_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_WINDOW_LEFT: win_left = data[LEFT_W-1:0];
            REG_WINDOW_TOP:  win_top  = data[LEFT_W-1:0];
            REG_WINDOW_COLS: win_cols = data[COLS_W-1:0];
            REG_WINDOW_ROWS: win_rows = data[COLS_W-1:0];
            REG_FRAME_COLS:  frm_cols = data[FRAME_W-1:0];
            REG_FRAME_ROWS:  frm_rows = data[FRAME_W-1:0];
            default: ;
        endcase
    endfunction

    function automatic void take_pixel(input logic [PIXEL_W-1:0] px, input logic last);
        int              fc;
        int              fr;
        int              x0;
        int              x1;
        int              y0;
        int              y1;
        bit              has_x;
        bit              has_y;
        longint unsigned area;
        mean_result_t    res;
        fc    = frame_dim(frm_cols);
        fr    = frame_dim(frm_rows);
        has_x = clip_axis(win_left, win_cols, fc, x0, x1);
        has_y = clip_axis(win_top, win_rows, fr, y0, y1);
        if (has_x && has_y && col_pos >= x0 && col_pos < x1 && row_pos >= y0 && row_pos < y1)
        begin
            red_acc   = red_acc   + px[RED_POS_DEF   +: CHAN_W];
            green_acc = green_acc + px[GREEN_POS_DEF +: CHAN_W];
            blue_acc  = blue_acc  + px[BLUE_POS_DEF  +: CHAN_W];
        end
        col_pos++;
        if (col_pos >= fc)
        begin
            col_pos = 0;
            row_pos++;
            if (row_pos >= fr)
                row_pos = 0;
        end
        if (last)
        begin
            res.mean_pixel = '0;
            if (has_x && has_y)
            begin
                // early frame end still divides by the full clipped area
                area = longint'(x1 - x0) * longint'(y1 - y0);
                res.mean_pixel[RED_POS_DEF   +: CHAN_W] = mean_chan(red_acc, area);
                res.mean_pixel[GREEN_POS_DEF +: CHAN_W] = mean_chan(green_acc, area);
                res.mean_pixel[BLUE_POS_DEF  +: CHAN_W] = mean_chan(blue_acc, area);
                res.window_empty = 1'b0;
            end
            else
            begin
                res.window_empty = 1'b1;
                empty_windows++;
            end
            mean_expect.push_back(res);
            col_pos   = 0;
            row_pos   = 0;
            red_acc   = '0;
            green_acc = '0;
            blue_acc  = '0;
        end
    endfunction

    // pixel sender
    always @(posedge clk or negedge rst_n)
    begin : pixel_driver
        pending_pixel_t item;
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            pixel      <= '0;
            frame_last <= 1'b0;
            tx_burst   = 0;
        end
        else if (!in_valid || in_ready)
        begin
            if (tx_burst > 0)
            begin
                tx_burst--;
                in_valid <= 1'b0;
            end
            else if (tx_idle_on && $urandom_range(0, 99) < IDLE_PCT)
            begin
                tx_burst = $urandom_range(1, 4) - 1;
                in_valid <= 1'b0;
            end
            else if (pixel_pending.size() != 0)
            begin
                item = pixel_pending.pop_front();
                in_valid   <= 1'b1;
                pixel      <= item.pixel;
                frame_last <= item.frame_last;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // result receiver; one long hold-off when armed, short random stalls otherwise
    always @(posedge clk or negedge rst_n)
    begin : mean_receiver
        logic ready_next;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            rx_burst  = 0;
            rx_hold   = 0;
            hold_done = 1'b0;
        end
        else
        begin
            if (hold_armed && !hold_done && out_valid)
            begin
                rx_hold   = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (rx_hold > 0)
            begin
                rx_hold--;
                ready_next = 1'b0;
            end
            else if (rx_burst > 0)
            begin
                rx_burst--;
                ready_next = 1'b0;
            end
            else if (rx_idle_on && $urandom_range(0, 99) < IDLE_PCT)
            begin
                rx_burst   = $urandom_range(1, 4) - 1;
                ready_next = 1'b0;
            end
            else
                ready_next = 1'b1;
            out_ready <= ready_next;
        end
    end

    always @(posedge clk)
    begin : mean_checker
        mean_result_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                results_seen++;
                if (mean_expect.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result, expected none, got mean_pixel %h empty %b",
                             $time, mean_pixel, window_empty);
                end
                else
                begin
                    want = mean_expect.pop_front();
                    if (want.mean_pixel !== mean_pixel)
                    begin
                        errors++;
                        $display("%0t: mean_pixel expected %h, got %h",
                                 $time, want.mean_pixel, mean_pixel);
                    end
                    if (want.window_empty !== window_empty)
                    begin
                        errors++;
                        $display("%0t: window_empty expected %b, got %b",
                                 $time, want.window_empty, window_empty);
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                take_pixel(pixel, frame_last);
                items_taken++;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
            begin
                quiet_cycles++;
                if (quiet_cycles >= QUIET_LIMIT)
                begin
                    $display("%0t: no request moved for %0d cycles", $time, QUIET_LIMIT);
                    $display("window_color_average test failed");
                    $finish;
                end
            end
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[CFG_DATA_W-1:0];
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        set_reg(idx, value[CFG_DATA_W-1:0]);
    endtask

    task automatic configure(input int left, input int top, input int cols, input int rows,
                             input int fcols, input int frows);
        write_reg(REG_FRAME_COLS, fcols);
        write_reg(REG_FRAME_ROWS, frows);
        write_reg(REG_WINDOW_LEFT, left);
        write_reg(REG_WINDOW_TOP, top);
        write_reg(REG_WINDOW_COLS, cols);
        write_reg(REG_WINDOW_ROWS, rows);
        settings_used++;
    endtask

    task automatic push_pixel(input logic [PIXEL_W-1:0] px, input logic last);
        pending_pixel_t item;
        item.pixel      = px;
        item.frame_last = last;
        pixel_pending.push_back(item);
        items_queued++;
    endtask

    task automatic push_frame(input int count);
        logic [PIXEL_W-1:0] px;
        for (int i = 0; i < count; i++)
        begin
            case ($urandom_range(0, 9))
                0:       px = '1;
                1:       px = '0;
                default: px = $urandom;
            endcase
            push_pixel(px, i == count - 1);
        end
    endtask

    // block idle: nothing queued, nothing outstanding, frame-end pipeline flushed
    task automatic wait_drained();
        while (pixel_pending.size() != 0 || in_valid || mean_expect.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin : stimulus
        int phase_no;
        int fc;
        int fr;
        int n;
        int shape;
        bit calm;
        phase_no = 0;
        calm     = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: 1x1 window at the origin of a 640x480 frame, ended early
        push_pixel(32'hFFFF_FFFF, 1'b0);
        push_pixel(32'h1234_5678, 1'b1);
        push_pixel(32'h0000_0000, 1'b1);
        wait_drained();

        // window hanging off the top-left corner
        configure(-1, -1, 3, 2, 3, 2);
        push_pixel(32'hFFFF_FFFF, 1'b0);
        push_pixel(32'h8080_8080, 1'b0);
        push_pixel(32'h00FF_00FF, 1'b0);
        push_pixel(32'hFF00_FF00, 1'b0);
        push_pixel(32'h0000_0001, 1'b0);
        push_pixel(32'h7F7F_7F7F, 1'b1);
        wait_drained();

        // negative width leaves nothing
        configure(0, 0, -2, 1, 2, 2);
        write_reg(REG_SPARE_A, 16'h3FFF);
        write_reg(REG_SPARE_B, 16'h2AAA);
        push_frame(4);
        wait_drained();

        // window past right and bottom edges, frame overrun wraps to the origin
        configure(1, 1, 4096, 4096, 2, 2);
        push_frame(7);
        wait_drained();

        // zero frame size is taken as 1x1
        configure(0, 0, 1, 1, 0, 0);
        push_frame(3);
        wait_drained();

        // register extremes on a saturated frame, both ended early
        configure(-4096, -4096, 8191, 8191, 8191, 8191);
        push_frame(40);
        wait_drained();
        configure(4095, 4095, -8192, 4096, 4096, 1);
        push_frame(10);

        while (items_queued < ITEM_TARGET)
        begin
            wait_drained();
            phase_no++;
            calm = items_queued > ITEM_TARGET * 9 / 10;
            if (phase_no == PRESSURE_PHASE)
                tx_idle_on <= 1'b0;
            else
                tx_idle_on <= !calm && $urandom_range(0, 3) != 0;
            rx_idle_on <= !calm && $urandom_range(0, 3) != 0;
            if (phase_no == PRESSURE_PHASE)
            begin
                // a result waits behind a stalled receiver; pixels keep coming until the next frame closes
                hold_armed <= 1'b1;
                configure(0, 0, 2, 2, 2, 2);
                repeat (16) push_frame(4);
            end
            else if ($urandom_range(0, 15) == 0)
            begin
                case ($urandom_range(0, 3))
                    0:       fc = 0;
                    1:       fc = MAX_DIM_DEF;
                    2:       fc = 8191;
                    default: fc = $urandom_range(0, 8191);
                endcase
                case ($urandom_range(0, 3))
                    0:       fr = 0;
                    1:       fr = MAX_DIM_DEF;
                    2:       fr = 8191;
                    default: fr = $urandom_range(0, 8191);
                endcase
                if ($urandom_range(0, 1) == 0)
                    configure($urandom_range(0, 12) - 4, $urandom_range(0, 6) - 2,
                              $urandom_range(0, 20), $urandom_range(0, 4), fc, fr);
                else
                    configure($urandom_range(0, 16383), $urandom_range(0, 16383),
                              $urandom_range(0, 16383), $urandom_range(0, 16383), fc, fr);
                repeat ($urandom_range(1, 2)) push_frame($urandom_range(1, 120));
            end
            else
            begin
                fc = $urandom_range(1, 10);
                fr = $urandom_range(1, 6);
                if ($urandom_range(0, 7) == 0)
                    configure($urandom_range(0, 16383), $urandom_range(0, 16383),
                              $urandom_range(0, 16383), $urandom_range(0, 16383), fc, fr);
                else
                    configure($urandom_range(0, fc + 4) - 3, $urandom_range(0, fr + 4) - 3,
                              $urandom_range(0, fc + 6) - 2, $urandom_range(0, fr + 6) - 2,
                              fc, fr);
                n = fc * fr;
                repeat ($urandom_range(1, 4))
                begin
                    shape = $urandom_range(0, 99);
                    if (shape < 70)
                        push_frame(n);
                    else if (shape < 85)
                        push_frame($urandom_range(1, n));
                    else
                        push_frame(n + $urandom_range(1, n + 3));
                end
            end
        end

        wait_drained();
        $display("%0d pixels over %0d window settings, %0d means checked (%0d empty windows)",
                 items_taken, settings_used, results_seen, empty_windows);
        $display("covered clipping on all edges, early and overrun frames, saturated frame sizes");
        if (errors == 0)
            $display("window_color_average test passed");
        else
            $display("window_color_average test failed");
        $finish;
    end

endmodule
